[rtl/core/bsa_pkg.sv]
`default_nettype none

package bsa_pkg;

  // Widths of the stream fields.
  localparam int FUNC_W = 2;
  localparam int CUST_W = 3;
  localparam int AMT_W = 8;
  localparam int STATUS_W = 2;
  localparam int MAX_RES = 3;
  localparam int FIELD_STRIDE = 8;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_USER_W = 3;

  // Configuration port.
  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_AVAILABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEMAND_BASE = 3'd1;

  // Operation codes carried in tuser.
  localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EXCEEDS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_UNSAFE = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_OVER_ALLOC = 2'd3;

  // Operand width of the shared unit. It holds an 8-bit amount, a signed
  // need and a work vector that sums every allocation plus the free pool.
  localparam int UNIT_W = 12;
  typedef logic signed [UNIT_W-1:0] uval_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

endpackage

`default_nettype wire

[rtl/core/banker_safe_allocator.sv]
`default_nettype none

// Banker's-algorithm admission controller. Each input item is a request, a
// release or a pool initialization for one customer; each produces exactly
// one result with the grant flag, a status code and the free counts after the
// operation. The block works on one item at a time through a single shared
// compare/add unit, one vector operation per cycle. Initialization, unused
// codes and out-of-range customers go straight to the final state. A release
// is checked against the allocation; a request is checked against the free
// pool and then against the need. A granted release subtracts the allocation
// and adds to the free pool. A request that passes both checks adds to the
// allocation and subtracts from the free pool, then runs the safety scan: up
// to CUSTOMERS passes over the customers, each visit followed by a work-vector
// add when the customer finishes; an unsafe request is undone the way a
// release is applied. The final state hands the result to the output register
// and holds while an earlier result still waits there. The input is ready again
// as soon as the result is in the output register, even if it is not yet taken.
module banker_safe_allocator
  import bsa_pkg::*;
#(
  parameter int CUSTOMERS = 5,
  parameter int RESOURCES = 3,
  parameter int COUNT_BITS = 8
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  // Configuration write port.
  input  wire                      cfg_we_i,
  input  wire  [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [CFG_W-1:0]         cfg_data_i,
  // Input stream.
  input  wire                      s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: customer[2:0], amount_r0[10:3], amount_r1[18:11], amount_r2[26:19]
  input  wire  [IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: func[1:0]
  input  wire  [FUNC_W-1:0]        s_axis_tuser,
  // Result stream.
  output logic                     m_axis_tvalid,
  input  wire                      m_axis_tready,
  // tdata: free_r0[7:0], free_r1[15:8], free_r2[23:16]
  output logic [OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: granted[0], status[2:1]
  output logic [OUT_USER_W-1:0]    m_axis_tuser
);

  localparam int CW = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
  localparam logic [CW-1:0] LAST_CUST = CW'(CUSTOMERS - 1);

  // Sequencer state codes.
  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE      = 4'd0;
  localparam logic [SW-1:0] S_CHK_FREE  = 4'd1;
  localparam logic [SW-1:0] S_CHK_NEED  = 4'd2;
  localparam logic [SW-1:0] S_ADD_ALLOC = 4'd3;
  localparam logic [SW-1:0] S_SUB_FREE  = 4'd4;
  localparam logic [SW-1:0] S_SCAN      = 4'd5;
  localparam logic [SW-1:0] S_SCAN_ADD  = 4'd6;
  localparam logic [SW-1:0] S_CHK_ALLOC = 4'd7;
  localparam logic [SW-1:0] S_SUB_ALLOC = 4'd8;
  localparam logic [SW-1:0] S_ADD_FREE  = 4'd9;
  localparam logic [SW-1:0] S_FIN       = 4'd10;

  // Configuration registers.
  logic [CFG_W-1:0]      init_q;
  logic [CFG_W-1:0]      max_q   [CUSTOMERS];

  // Pool state.
  logic [COUNT_BITS-1:0] free_q  [RESOURCES];
  logic [COUNT_BITS-1:0] alloc_q [CUSTOMERS][RESOURCES];

  // Item and scan state.
  logic [SW-1:0]         state_q;
  logic [CW-1:0]         cust_q;
  logic [CW-1:0]         ptr_q;
  logic [CW-1:0]         pass_q;
  logic [AMT_W-1:0]      amt_q   [RESOURCES];
  uval_t                 work_q  [RESOURCES];
  logic [CUSTOMERS-1:0]  done_q;
  logic                  granted_q;
  logic [STATUS_W-1:0]   status_q;

  // Output register.
  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic [OUT_USER_W-1:0] m_user_q;

  // Shared unit.
  alu_op_e               alu_op;
  uval_t                 alu_a   [RESOURCES];
  uval_t                 alu_b   [RESOURCES];
  logic                  alu_le;
  uval_t                 alu_sum [RESOURCES];

  uval_t                 need    [RESOURCES];
  uval_t                 amt_x   [RESOURCES];
  uval_t                 free_x  [RESOURCES];
  uval_t                 alloc_x [RESOURCES];
  logic [OUT_DATA_W-1:0] free_pack;

  logic                  in_xfer;
  logic [CUST_W-1:0]     in_cust;
  logic                  in_cust_bad;
  logic                  last_cust;
  logic                  last_pass;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign in_cust     = s_axis_tdata[CUST_W-1:0];
  assign in_cust_bad = in_cust >= CUST_W'(CUSTOMERS);
  assign last_cust   = ptr_q == LAST_CUST;
  assign last_pass   = pass_q == LAST_CUST;

  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Extended views of the current customer's entries; need may go negative
  // when a maximum is lowered below the allocation.
  always_comb begin
    for (int r = 0; r < RESOURCES; r++) begin
      amt_x[r]   = UNIT_W'(amt_q[r]);
      free_x[r]  = UNIT_W'(free_q[r]);
      alloc_x[r] = UNIT_W'(alloc_q[ptr_q][r]);
      need[r]    = UNIT_W'(max_q[ptr_q][FIELD_STRIDE*r +: COUNT_BITS]) - alloc_x[r];
    end
  end

  // Operand selection for the shared unit.
  always_comb begin
    alu_op = ALU_ADD;
    for (int r = 0; r < RESOURCES; r++) begin
      alu_a[r] = amt_x[r];
      alu_b[r] = free_x[r];
      case (state_q)
        S_CHK_FREE: begin
          alu_a[r] = amt_x[r];
          alu_b[r] = free_x[r];
        end
        S_CHK_NEED: begin
          alu_a[r] = amt_x[r];
          alu_b[r] = need[r];
        end
        S_CHK_ALLOC: begin
          alu_a[r] = amt_x[r];
          alu_b[r] = alloc_x[r];
        end
        S_ADD_ALLOC: begin
          alu_a[r] = alloc_x[r];
          alu_b[r] = amt_x[r];
        end
        S_SUB_FREE: begin
          alu_op   = ALU_SUB;
          alu_a[r] = free_x[r];
          alu_b[r] = amt_x[r];
        end
        S_SUB_ALLOC: begin
          alu_op   = ALU_SUB;
          alu_a[r] = alloc_x[r];
          alu_b[r] = amt_x[r];
        end
        S_ADD_FREE: begin
          alu_a[r] = free_x[r];
          alu_b[r] = amt_x[r];
        end
        S_SCAN: begin
          alu_a[r] = need[r];
          alu_b[r] = work_q[r];
        end
        S_SCAN_ADD: begin
          alu_a[r] = work_q[r];
          alu_b[r] = alloc_x[r];
        end
        default: begin
          alu_a[r] = amt_x[r];
          alu_b[r] = free_x[r];
        end
      endcase
    end
  end

  bsa_alu #(
    .Lanes(RESOURCES)
  ) u_alu (
    .op_i    (alu_op),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .le_all_o(alu_le),
    .sum_o   (alu_sum)
  );

  // Free counts as they appear in the result; unused resources read zero.
  always_comb begin
    free_pack = '0;
    for (int r = 0; r < RESOURCES; r++) begin
      free_pack[FIELD_STRIDE*r +: FIELD_STRIDE] = FIELD_STRIDE'(free_q[r]);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
      for (int c = 0; c < CUSTOMERS; c++) begin
        max_q[c] <= '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_INITIAL_AVAILABLE) begin
        init_q <= cfg_data_i;
      end
      for (int c = 0; c < CUSTOMERS; c++) begin
        if (cfg_idx_i == CFG_MAX_DEMAND_BASE + CFG_IDX_W'(c)) begin
          max_q[c] <= cfg_data_i;
        end
      end
    end
  end

  // Sequencer, pool state and scan state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cust_q    <= '0;
      ptr_q     <= '0;
      pass_q    <= '0;
      done_q    <= '0;
      granted_q <= 1'b0;
      status_q  <= STATUS_OK;
      for (int r = 0; r < RESOURCES; r++) begin
        free_q[r] <= '0;
        amt_q[r]  <= '0;
        work_q[r] <= '0;
        for (int c = 0; c < CUSTOMERS; c++) begin
          alloc_q[c][r] <= '0;
        end
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_xfer) begin
            cust_q    <= in_cust[CW-1:0];
            ptr_q     <= in_cust[CW-1:0];
            granted_q <= 1'b0;
            status_q  <= STATUS_OK;
            for (int r = 0; r < RESOURCES; r++) begin
              amt_q[r] <= s_axis_tdata[CUST_W + AMT_W*r +: AMT_W];
            end
            case (s_axis_tuser)
              FUNC_INIT: begin
                granted_q <= 1'b1;
                for (int r = 0; r < RESOURCES; r++) begin
                  free_q[r] <= init_q[FIELD_STRIDE*r +: COUNT_BITS];
                  for (int c = 0; c < CUSTOMERS; c++) begin
                    alloc_q[c][r] <= '0;
                  end
                end
                state_q <= S_FIN;
              end
              FUNC_REQUEST: begin
                if (in_cust_bad) begin
                  status_q <= STATUS_EXCEEDS;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_CHK_FREE;
                end
              end
              FUNC_RELEASE: begin
                if (in_cust_bad) begin
                  status_q <= STATUS_OVER_ALLOC;
                  state_q  <= S_FIN;
                end else begin
                  state_q <= S_CHK_ALLOC;
                end
              end
              default: begin
                state_q <= S_FIN;
              end
            endcase
          end
        end
        S_CHK_FREE: begin
          if (alu_le) begin
            state_q <= S_CHK_NEED;
          end else begin
            status_q <= STATUS_EXCEEDS;
            state_q  <= S_FIN;
          end
        end
        S_CHK_NEED: begin
          if (alu_le) begin
            state_q <= S_ADD_ALLOC;
          end else begin
            status_q <= STATUS_EXCEEDS;
            state_q  <= S_FIN;
          end
        end
        S_ADD_ALLOC: begin
          for (int r = 0; r < RESOURCES; r++) begin
            alloc_q[ptr_q][r] <= alu_sum[r][COUNT_BITS-1:0];
          end
          state_q <= S_SUB_FREE;
        end
        // Tentative grant is in place; the work vector starts at the new pool.
        S_SUB_FREE: begin
          for (int r = 0; r < RESOURCES; r++) begin
            free_q[r] <= alu_sum[r][COUNT_BITS-1:0];
            work_q[r] <= alu_sum[r];
          end
          done_q  <= '0;
          ptr_q   <= '0;
          pass_q  <= '0;
          state_q <= S_SCAN;
        end
        // Visit one customer: finish it if its need fits the work vector.
        S_SCAN: begin
          if (!done_q[ptr_q] && alu_le) begin
            done_q[ptr_q] <= 1'b1;
            state_q       <= S_SCAN_ADD;
          end else if (last_cust) begin
            if (last_pass) begin
              ptr_q    <= cust_q;
              status_q <= STATUS_UNSAFE;
              state_q  <= S_SUB_ALLOC;
            end else begin
              pass_q <= pass_q + 1'b1;
              ptr_q  <= '0;
            end
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        // Return the finished customer's allocation to the work vector.
        S_SCAN_ADD: begin
          for (int r = 0; r < RESOURCES; r++) begin
            work_q[r] <= alu_sum[r];
          end
          if (&done_q) begin
            granted_q <= 1'b1;
            state_q   <= S_FIN;
          end else if (last_cust) begin
            if (last_pass) begin
              ptr_q    <= cust_q;
              status_q <= STATUS_UNSAFE;
              state_q  <= S_SUB_ALLOC;
            end else begin
              pass_q  <= pass_q + 1'b1;
              ptr_q   <= '0;
              state_q <= S_SCAN;
            end
          end else begin
            ptr_q   <= ptr_q + 1'b1;
            state_q <= S_SCAN;
          end
        end
        S_CHK_ALLOC: begin
          if (alu_le) begin
            granted_q <= 1'b1;
            state_q   <= S_SUB_ALLOC;
          end else begin
            status_q <= STATUS_OVER_ALLOC;
            state_q  <= S_FIN;
          end
        end
        // Shared by a release and by the undo of an unsafe request.
        S_SUB_ALLOC: begin
          for (int r = 0; r < RESOURCES; r++) begin
            alloc_q[ptr_q][r] <= alu_sum[r][COUNT_BITS-1:0];
          end
          state_q <= S_ADD_FREE;
        end
        S_ADD_FREE: begin
          for (int r = 0; r < RESOURCES; r++) begin
            free_q[r] <= alu_sum[r][COUNT_BITS-1:0];
          end
          state_q <= S_FIN;
        end
        // Hand the result to the output register once it is free.
        S_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Output register; the next item may start while a result waits here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= '0;
    end else if (state_q == S_FIN && (!m_valid_q || m_axis_tready)) begin
      m_valid_q <= 1'b1;
      m_data_q  <= free_pack;
      m_user_q  <= {status_q, granted_q};
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bsa_alu.sv]
`default_nettype none

// Shared add/subtract and compare unit, one lane per resource.
module bsa_alu
  import bsa_pkg::*;
#(
  parameter int Lanes = 3
) (
  input  alu_op_e op_i,
  input  uval_t   a_i     [Lanes],
  input  uval_t   b_i     [Lanes],
  output logic    le_all_o,
  output uval_t   sum_o   [Lanes]
);

  // Every lane must satisfy a <= b (signed) for the vector to fit.
  always_comb begin
    le_all_o = 1'b1;
    for (int r = 0; r < Lanes; r++) begin
      if (a_i[r] > b_i[r]) begin
        le_all_o = 1'b0;
      end
    end
  end

  // Lane-wise sum or difference.
  always_comb begin
    for (int r = 0; r < Lanes; r++) begin
      if (op_i == ALU_SUB) begin
        sum_o[r] = a_i[r] - b_i[r];
      end else begin
        sum_o[r] = a_i[r] + b_i[r];
      end
    end
  end

endmodule

`default_nettype wire

[tb/sv/tb.sv]
module tb;
  import bsa_pkg::*;

  localparam int NUM_CUST = 5;
  localparam int NUM_RES = 3;
  localparam int PAD_W = IN_DATA_W - CUST_W - MAX_RES * AMT_W;
  localparam int IDLE_PCT = 12;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 210;

  // The one operation code that the block defines as doing nothing.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  typedef logic [MAX_RES-1:0][AMT_W-1:0] counts_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CUST_W-1:0] customer;
    counts_t           amount;
  } order_t;

  typedef struct packed {
    logic                granted;
    logic [STATUS_W-1:0] status;
    counts_t             free_cnt;
  } verdict_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [FUNC_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;

  // Shadow of the allocator: registers, free pool and per-customer holdings.
  counts_t          avail_reg = '0;
  counts_t          demand [NUM_CUST] = '{default: '0};
  counts_t          pool = '0;
  bit [AMT_W-1:0]   held [NUM_CUST][MAX_RES] = '{default: '0};

  order_t   pending_q [$];
  verdict_t verdict_q [$];
  order_t   offered;
  bit       steady = 1'b0;
  int       fault_count = 0;
  int       stall_cycles = 0;

  banker_safe_allocator #(
    .CUSTOMERS (NUM_CUST),
    .RESOURCES (NUM_RES),
    .COUNT_BITS(AMT_W)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  // Applies one order to the shadow state and returns the verdict it earns.
  function automatic verdict_t apply_order(order_t ord);
    verdict_t v;
    int       c;
    int       work [NUM_RES];
    bit       done [NUM_CUST];
    int       finished;
    bit       ok;
    bit       fits;
    v.granted = 1'b0;
    v.status = STATUS_OK;
    c = ord.customer;
    case (ord.func)
      FUNC_INIT: begin
        pool = avail_reg;
        held = '{default: '0};
        v.granted = 1'b1;
      end
      FUNC_REQUEST: begin
        if (c >= NUM_CUST) begin
          v.status = STATUS_EXCEEDS;
        end else begin
          ok = 1'b1;
          for (int r = 0; r < NUM_RES; r++) begin
            if (ord.amount[r] > pool[r] ||
                int'(ord.amount[r]) > int'(demand[c][r]) - int'(held[c][r])) ok = 1'b0;
          end
          if (!ok) begin
            v.status = STATUS_EXCEEDS;
          end else begin
            for (int r = 0; r < NUM_RES; r++) begin
              held[c][r] += ord.amount[r];
              pool[r] -= ord.amount[r];
            end
            // Safety scan: repeated passes, finishing every customer whose
            // remaining need fits in the work vector.
            for (int r = 0; r < NUM_RES; r++) work[r] = pool[r];
            done = '{default: 1'b0};
            finished = 0;
            for (int p = 0; p < NUM_CUST && finished < NUM_CUST; p++) begin
              for (int k = 0; k < NUM_CUST && finished < NUM_CUST; k++) begin
                if (!done[k]) begin
                  fits = 1'b1;
                  for (int r = 0; r < NUM_RES; r++) begin
                    if (int'(demand[k][r]) - int'(held[k][r]) > work[r]) fits = 1'b0;
                  end
                  if (fits) begin
                    done[k] = 1'b1;
                    finished++;
                    for (int r = 0; r < NUM_RES; r++) work[r] += held[k][r];
                  end
                end
              end
            end
            if (finished == NUM_CUST) begin
              v.granted = 1'b1;
            end else begin
              for (int r = 0; r < NUM_RES; r++) begin
                held[c][r] -= ord.amount[r];
                pool[r] += ord.amount[r];
              end
              v.status = STATUS_UNSAFE;
            end
          end
        end
      end
      FUNC_RELEASE: begin
        if (c >= NUM_CUST) begin
          v.status = STATUS_OVER_ALLOC;
        end else begin
          ok = 1'b1;
          for (int r = 0; r < NUM_RES; r++) begin
            if (ord.amount[r] > held[c][r]) ok = 1'b0;
          end
          if (!ok) begin
            v.status = STATUS_OVER_ALLOC;
          end else begin
            for (int r = 0; r < NUM_RES; r++) begin
              held[c][r] -= ord.amount[r];
              pool[r] += ord.amount[r];
            end
            v.granted = 1'b1;
          end
        end
      end
      default: ;
    endcase
    v.free_cnt = pool;
    return v;
  endfunction

  function automatic bit skip_cycle();
    return !steady && ($urandom_range(99, 0) < IDLE_PCT);
  endfunction

  function automatic counts_t pack3(int a0, int a1, int a2);
    counts_t p;
    p[0] = AMT_W'(a0);
    p[1] = AMT_W'(a1);
    p[2] = AMT_W'(a2);
    return p;
  endfunction

  function automatic counts_t rand3(int lo, int hi);
    return pack3($urandom_range(hi, lo), $urandom_range(hi, lo), $urandom_range(hi, lo));
  endfunction

  task automatic add_order(input logic [FUNC_W-1:0] f, input int c, input counts_t amt);
    order_t ord;
    ord.func = f;
    ord.customer = CUST_W'(c);
    ord.amount = amt;
    pending_q.push_back(ord);
  endtask

  // Mostly well-formed traffic with small amounts, plus noise.
  task automatic add_random(input int count, input int scale);
    int pick;
    int c;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99, 0);
      c = $urandom_range(NUM_CUST - 1, 0);
      if (pick < 3) begin
        add_order(FUNC_UNUSED, $urandom_range(7, 0), rand3(0, 255));
      end else if (pick < 6) begin
        add_order(FUNC_INIT, $urandom_range(7, 0), rand3(0, 255));
      end else if (pick < 11) begin
        add_order(pick[0] ? FUNC_RELEASE : FUNC_REQUEST, $urandom_range(7, NUM_CUST),
                  rand3(0, scale));
      end else if (pick < 16) begin
        add_order(pick[0] ? FUNC_RELEASE : FUNC_REQUEST, c, rand3(0, 255));
      end else if (pick < 62) begin
        add_order(FUNC_REQUEST, c, rand3(0, scale));
      end else begin
        add_order(FUNC_RELEASE, c, rand3(0, scale));
      end
    end
  endtask

  // Returns at a rising edge once every order has had its verdict.
  task automatic wait_drained();
    while (pending_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Writes every register; called at a rising edge with the block idle.
  task automatic load_config(input counts_t avail, input counts_t dem [NUM_CUST]);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_INITIAL_AVAILABLE;
    cfg_data_i <= avail;
    avail_reg = avail;
    @(posedge clk_i);
    for (int k = 0; k < NUM_CUST; k++) begin
      cfg_idx_i <= CFG_MAX_DEMAND_BASE + CFG_IDX_W'(k);
      cfg_data_i <= dem[k];
      demand[k] = dem[k];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic note_fault(input string what, input int want, input int got);
    fault_count++;
    if (fault_count <= 10) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
  endtask

  // Driver: offers queued orders and predicts each one as its transfer completes.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        verdict_q.push_back(apply_order(offered));
      end
      if (pending_q.size() != 0 && !skip_cycle()) begin
        offered = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{PAD_W{1'b0}}, offered.amount, offered.customer};
        s_axis_tuser <= offered.func;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: checks each result transfer against the oldest verdict.
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (verdict_q.size() == 0) begin
          note_fault("unexpected result", -1, m_axis_tuser);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tuser[0] !== want.granted) begin
            note_fault("granted", want.granted, m_axis_tuser[0]);
          end
          if (m_axis_tuser[2:1] !== want.status) begin
            note_fault("status", want.status, m_axis_tuser[2:1]);
          end
          for (int r = 0; r < NUM_RES; r++) begin
            if (m_axis_tdata[r*AMT_W +: AMT_W] !== want.free_cnt[r]) begin
              note_fault($sformatf("free_r%0d", r), want.free_cnt[r],
                         m_axis_tdata[r*AMT_W +: AMT_W]);
            end
          end
        end
      end
      m_axis_tready <= !skip_cycle();
    end
  end

  // Watchdog on cycles without any transfer or register write.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    counts_t avail_cfg;
    counts_t dem_cfg [NUM_CUST];
    int      scale;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Before any register write: everything is zero.
    add_order(FUNC_UNUSED, 0, pack3(0, 0, 0));
    add_order(FUNC_REQUEST, 0, pack3(0, 0, 0));
    add_order(FUNC_REQUEST, 0, pack3(1, 0, 0));
    add_order(FUNC_RELEASE, 0, pack3(0, 0, 0));
    wait_drained();

    // Textbook five-customer, three-resource case.
    avail_cfg = pack3(10, 5, 7);
    dem_cfg = '{pack3(7, 5, 3), pack3(3, 2, 2), pack3(9, 0, 2), pack3(2, 2, 2),
                pack3(4, 3, 3)};
    load_config(avail_cfg, dem_cfg);
    add_order(FUNC_INIT, 0, pack3(0, 0, 0));
    add_order(FUNC_REQUEST, 0, pack3(0, 1, 0));
    add_order(FUNC_REQUEST, 1, pack3(2, 0, 0));
    add_order(FUNC_REQUEST, 2, pack3(3, 0, 2));
    add_order(FUNC_REQUEST, 3, pack3(2, 1, 1));
    add_order(FUNC_REQUEST, 4, pack3(0, 0, 2));
    add_order(FUNC_REQUEST, 1, pack3(1, 0, 2));
    add_order(FUNC_REQUEST, 4, pack3(3, 3, 0));
    add_order(FUNC_REQUEST, 0, pack3(0, 2, 0));
    add_order(FUNC_RELEASE, 1, pack3(9, 0, 0));
    add_order(FUNC_RELEASE, 2, pack3(3, 0, 2));
    add_order(FUNC_REQUEST, 5, pack3(1, 1, 1));
    add_order(FUNC_RELEASE, 7, pack3(0, 0, 0));
    add_order(FUNC_UNUSED, 6, pack3(255, 255, 255));
    add_order(FUNC_REQUEST, 3, pack3(255, 255, 255));
    add_order(FUNC_RELEASE, 0, pack3(0, 0, 0));
    add_order(FUNC_RELEASE, 4, pack3(255, 0, 0));
    add_order(FUNC_REQUEST, 0, pack3(0, 0, 0));
    wait_drained();

    // Random phases, each under its own register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      scale = 3;
      case (ph)
        0: begin
          avail_cfg = pack3(255, 255, 255);
          for (int k = 0; k < NUM_CUST; k++) dem_cfg[k] = pack3(255, 255, 255);
          scale = 60;
        end
        1: begin
          avail_cfg = '0;
          for (int k = 0; k < NUM_CUST; k++) dem_cfg[k] = '0;
          scale = 1;
        end
        2: begin
          avail_cfg = rand3(30, 60);
          for (int k = 0; k < NUM_CUST; k++) dem_cfg[k] = rand3(10, 25);
          scale = 4;
        end
        3: begin
          // Maximums drop under what customers already hold.
          for (int k = 0; k < NUM_CUST; k++) dem_cfg[k] = rand3(0, 3);
        end
        default: begin
          avail_cfg = rand3(0, 48);
          for (int k = 0; k < NUM_CUST; k++) dem_cfg[k] = rand3(0, 24);
        end
      endcase
      steady = (ph == 5);
      load_config(avail_cfg, dem_cfg);
      if (ph != 3) add_order(FUNC_INIT, 0, pack3(0, 0, 0));
      add_random(PHASE_ITEMS, scale);
      wait_drained();
    end
    steady = 1'b0;

    repeat (64) @(posedge clk_i);
    if (fault_count == 0 && verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
